/* rtl/amfm_pkg.sv */
package amfm_pkg;

    localparam int SAMPLE_BITS  = 16;
    localparam int MAG_BITS     = SAMPLE_BITS - 1;
    localparam int DEPTH_BITS   = 16;
    localparam int STEP_BITS    = 31;
    localparam int CFG_IDX_BITS = 2;
    localparam int GAIN_BITS    = DEPTH_BITS + SAMPLE_BITS + 1;
    localparam int MUL_A_BITS   = STEP_BITS;
    localparam int MUL_B_BITS   = GAIN_BITS - DEPTH_BITS;
    localparam int PROD_BITS    = MUL_A_BITS + MUL_B_BITS;
    localparam int ACC_BITS     = MAG_BITS + GAIN_BITS;
    localparam int SEQ_LEN      = 9;
    localparam int SEQ_IDX_BITS = $clog2(SEQ_LEN);

    localparam logic [STEP_BITS-1:0] LFO_STEP_RESET = 31'd3895662;
    localparam logic [STEP_BITS-1:0] OFS_STEP_RESET = 31'd19478310;
    localparam logic [STEP_BITS-1:0] RNG_STEP_RESET = 31'd97391549;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_LFO_STEP = 2'd0,
        CFG_OFS_STEP = 2'd1,
        CFG_RNG_STEP = 2'd2
    } amfm_cfg_idx_t;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LFO,
        OP_CAR,
        OP_GAIN,
        OP_FMU,
        OP_ACC_LO,
        OP_ACC_HI,
        OP_STEP,
        OP_OUT
    } amfm_op_t;

    typedef enum logic [1:0] {
        COND_NONE,
        COND_NO_INPUT,
        COND_OUT_BUSY
    } amfm_cond_t;

    typedef struct packed {
        amfm_op_t                op;
        amfm_cond_t              cond;
        logic [SEQ_IDX_BITS-1:0] tgt;
    } amfm_ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic out_busy;
    } amfm_status_t;

    typedef struct packed {
        logic [STEP_BITS-1:0] lfo_step;
        logic [STEP_BITS-1:0] ofs_step;
        logic [STEP_BITS-1:0] rng_step;
    } amfm_cfg_t;

    typedef struct packed {
        logic [DEPTH_BITS-1:0] am_depth;
        logic [DEPTH_BITS-1:0] fm_depth;
    } amfm_in_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] audio_out;
        logic signed [SAMPLE_BITS-1:0] lfo_value;
    } amfm_out_t;

endpackage

/* rtl/amfm_sine_rom.sv */
module amfm_sine_rom #(
    parameter int ADDR_BITS = 10
) (
    input  logic                              aclk,
    input  logic [ADDR_BITS+1:0]              idx,
    output logic [amfm_pkg::MAG_BITS-1:0]     mag,
    output logic                              neg
);
    import amfm_pkg::*;

    localparam int QTR = 1 << ADDR_BITS;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] PEAK_AMP = (64'd1 << MAG_BITS) - 64'd1;

    typedef logic [MAG_BITS-1:0] rom_t [QTR];

    function automatic rom_t build_rom();
        rom_t               r;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        e;
        logic signed [63:0] sum;
        for (int i = 0; i < QTR; i++) begin
            x    = (HALF_PI_Q30 * 64'(2 * i + 1)) >> (ADDR_BITS + 1);
            x2   = (x * x) >> 30;
            term = x;
            sum  = signed'(x);
            term = ((term * x2) >> 30) / 6;   sum = sum - signed'(term);
            term = ((term * x2) >> 30) / 20;  sum = sum + signed'(term);
            term = ((term * x2) >> 30) / 42;  sum = sum - signed'(term);
            term = ((term * x2) >> 30) / 72;  sum = sum + signed'(term);
            term = ((term * x2) >> 30) / 110; sum = sum - signed'(term);
            term = ((term * x2) >> 30) / 156; sum = sum + signed'(term);
            term = ((term * x2) >> 30) / 210; sum = sum - signed'(term);
            term = ((term * x2) >> 30) / 272; sum = sum + signed'(term);
            if (sum < 0) begin
                sum = 64'sd0;
            end
            e = (unsigned'(sum) * PEAK_AMP + (64'd1 << 29)) >> 30;
            if (e > PEAK_AMP) begin
                e = PEAK_AMP;
            end
            r[i] = e[MAG_BITS-1:0];
        end
        return r;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    logic [1:0]           quad;
    logic [ADDR_BITS-1:0] addr;
    logic [MAG_BITS-1:0]  mag_reg;
    logic                 neg_reg;

    assign quad = idx[ADDR_BITS+1:ADDR_BITS];
    assign addr = quad[0] ? ~idx[ADDR_BITS-1:0] : idx[ADDR_BITS-1:0];

    always_ff @(posedge aclk) begin
        mag_reg <= SINE_ROM[addr];
        neg_reg <= quad[1];
    end

    assign mag = mag_reg;
    assign neg = neg_reg;

endmodule

/* rtl/amfm_sequencer.sv */
module amfm_sequencer (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  amfm_pkg::amfm_status_t status,
    output amfm_pkg::amfm_ctrl_t   ctrl
);
    import amfm_pkg::*;

    localparam logic [SEQ_IDX_BITS-1:0] LAST = SEQ_IDX_BITS'(SEQ_LEN - 1);

    localparam amfm_ctrl_t PROGRAM [SEQ_LEN] = '{
        '{op: OP_IDLE,   cond: COND_NO_INPUT, tgt: 4'd0},
        '{op: OP_LFO,    cond: COND_NONE,     tgt: 4'd0},
        '{op: OP_CAR,    cond: COND_NONE,     tgt: 4'd0},
        '{op: OP_GAIN,   cond: COND_NONE,     tgt: 4'd0},
        '{op: OP_FMU,    cond: COND_NONE,     tgt: 4'd0},
        '{op: OP_ACC_LO, cond: COND_NONE,     tgt: 4'd0},
        '{op: OP_ACC_HI, cond: COND_NONE,     tgt: 4'd0},
        '{op: OP_STEP,   cond: COND_NONE,     tgt: 4'd0},
        '{op: OP_OUT,    cond: COND_OUT_BUSY, tgt: LAST}
    };

    logic [SEQ_IDX_BITS-1:0] step_reg;
    logic [SEQ_IDX_BITS-1:0] step_next;
    amfm_ctrl_t              word;
    logic                    jump;

    assign word = PROGRAM[step_reg];

    always_comb begin
        case (word.cond)
            COND_NO_INPUT: jump = !status.in_valid;
            COND_OUT_BUSY: jump = status.out_busy;
            default:       jump = 1'b0;
        endcase
        if (jump) begin
            step_next = word.tgt;
        end else if (step_reg == LAST) begin
            step_next = '0;
        end else begin
            step_next = step_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
        end else begin
            step_reg <= step_next;
        end
    end

    assign ctrl = word;

endmodule

/* rtl/amfm_datapath.sv */
module amfm_datapath #(
    parameter int PHASE_BITS = 32,
    parameter int ADDR_BITS  = 10
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  amfm_pkg::amfm_op_t             op,
    input  logic                           accept,
    input  logic                           commit,
    input  amfm_pkg::amfm_in_t             in_data,
    input  amfm_pkg::amfm_cfg_t            cfg,
    output logic [ADDR_BITS+1:0]           rom_idx,
    input  logic [amfm_pkg::MAG_BITS-1:0]  rom_mag,
    input  logic                           rom_neg,
    output amfm_pkg::amfm_out_t            result
);
    import amfm_pkg::*;

    localparam int SUM_BITS = (PHASE_BITS > 32) ? PHASE_BITS : 32;
    localparam int IDX_BITS = ADDR_BITS + 2;

    logic [PHASE_BITS-1:0]         car_phase_reg;
    logic [PHASE_BITS-1:0]         lfo_phase_reg;
    logic [PHASE_BITS-1:0]         step_reg;
    logic [DEPTH_BITS-1:0]         am_reg;
    logic [DEPTH_BITS-1:0]         fm_reg;
    logic signed [SAMPLE_BITS-1:0] lfo_reg;
    logic [MAG_BITS-1:0]           car_mag_reg;
    logic                          car_neg_reg;
    logic [GAIN_BITS-1:0]          gain_reg;
    logic [DEPTH_BITS-1:0]         fmu_reg;
    logic [PROD_BITS-1:0]          prod_reg;
    logic [ACC_BITS-1:0]           acc_reg;
    logic [MAG_BITS-1:0]           mag_reg;

    logic [SAMPLE_BITS-1:0]        u;
    logic [MUL_A_BITS-1:0]         mul_a;
    logic [MUL_B_BITS-1:0]         mul_b;
    logic [SAMPLE_BITS-1:0]        lfo_abs;
    logic [SUM_BITS-1:0]           step_sum;
    logic [SUM_BITS-1:0]           lfo_sum;
    logic [ACC_BITS-1:0]           rnd;

    assign u = {~lfo_reg[SAMPLE_BITS-1], lfo_reg[SAMPLE_BITS-2:0]};

    assign rom_idx = (op == OP_LFO) ? car_phase_reg[PHASE_BITS-1 -: IDX_BITS]
                                    : lfo_phase_reg[PHASE_BITS-1 -: IDX_BITS];

    always_comb begin
        case (op)
            OP_CAR: begin
                mul_a = MUL_A_BITS'(am_reg);
                mul_b = MUL_B_BITS'(u);
            end
            OP_GAIN: begin
                mul_a = MUL_A_BITS'(fm_reg);
                mul_b = MUL_B_BITS'(u);
            end
            OP_FMU: begin
                mul_a = MUL_A_BITS'(car_mag_reg);
                mul_b = MUL_B_BITS'(gain_reg[DEPTH_BITS-1:0]);
            end
            OP_ACC_LO: begin
                mul_a = MUL_A_BITS'(car_mag_reg);
                mul_b = gain_reg[GAIN_BITS-1:DEPTH_BITS];
            end
            OP_ACC_HI: begin
                mul_a = cfg.rng_step;
                mul_b = MUL_B_BITS'(fmu_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign lfo_abs  = {1'b0, rom_mag};
    assign step_sum = SUM_BITS'(cfg.ofs_step) + SUM_BITS'(prod_reg[PROD_BITS-2:DEPTH_BITS]);
    assign lfo_sum  = SUM_BITS'(lfo_phase_reg) + SUM_BITS'(cfg.lfo_step);
    assign rnd      = acc_reg + (ACC_BITS'(1) << (GAIN_BITS - 2));

    always_ff @(posedge aclk) begin
        prod_reg <= PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
        if (accept) begin
            am_reg <= in_data.am_depth;
            fm_reg <= in_data.fm_depth;
        end
        case (op)
            OP_LFO: begin
                lfo_reg <= rom_neg ? -signed'(lfo_abs) : signed'(lfo_abs);
            end
            OP_CAR: begin
                car_mag_reg <= rom_mag;
                car_neg_reg <= rom_neg;
            end
            OP_GAIN: begin
                gain_reg <= (GAIN_BITS'(1) << (GAIN_BITS - 1))
                            - GAIN_BITS'(prod_reg[2*DEPTH_BITS-1:0]);
            end
            OP_FMU: begin
                fmu_reg <= prod_reg[SAMPLE_BITS +: DEPTH_BITS];
            end
            OP_ACC_LO: begin
                acc_reg <= ACC_BITS'(prod_reg);
            end
            OP_ACC_HI: begin
                acc_reg <= acc_reg
                           + (ACC_BITS'(prod_reg[MAG_BITS+MUL_B_BITS-1:0]) << DEPTH_BITS);
            end
            OP_STEP: begin
                mag_reg <= rnd[GAIN_BITS-1 +: MAG_BITS];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            car_phase_reg <= '0;
            lfo_phase_reg <= '0;
            step_reg      <= '0;
        end else begin
            if (op == OP_STEP) begin
                step_reg <= step_sum[PHASE_BITS-1:0];
            end
            if (commit) begin
                car_phase_reg <= car_phase_reg + step_reg;
                lfo_phase_reg <= lfo_sum[PHASE_BITS-1:0];
            end
        end
    end

    always_comb begin
        result.lfo_value = lfo_reg;
        result.audio_out = car_neg_reg ? -signed'({1'b0, mag_reg}) : signed'({1'b0, mag_reg});
    end

endmodule

/* rtl/am_fm_modulated_oscillator.sv */
// A request is taken only in the idle step, then runs the LFO, CAR, GAIN, FMU, ACC_LO,
// ACC_HI, STEP and OUT steps; OUT waits while the output register is full. Every product
// goes through the one shared 31 x 17 multiplier, and both sines come from one ROM port.
// Reset is synchronous and active low: step registers return to their defaults, both
// phase accumulators clear to zero and the output register empties; there is no clearing pass.
module am_fm_modulated_oscillator #(
    parameter int PHASE_BITS           = 32,
    parameter int SINE_TABLE_ADDR_BITS = 10
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  amfm_pkg::amfm_in_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output amfm_pkg::amfm_out_t                 m_data,
    input  logic                                cfg_wr_en,
    input  logic [amfm_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [amfm_pkg::STEP_BITS-1:0]      cfg_wdata
);
    import amfm_pkg::*;

    amfm_ctrl_t                     ctrl;
    amfm_status_t                   status;
    amfm_cfg_t                      cfg_reg;
    amfm_out_t                      result;
    amfm_out_t                      out_reg;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic                           accept;
    logic                           commit;
    logic [SINE_TABLE_ADDR_BITS+1:0] rom_idx;
    logic [MAG_BITS-1:0]            rom_mag;
    logic                           rom_neg;

    assign status.in_valid = s_valid;
    assign status.out_busy = out_valid_reg && !m_ready;
    assign s_ready         = (ctrl.op == OP_IDLE);
    assign accept          = s_valid && s_ready;
    assign commit          = (ctrl.op == OP_OUT) && !status.out_busy;

    amfm_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    amfm_sine_rom #(
        .ADDR_BITS (SINE_TABLE_ADDR_BITS)
    ) u_rom (
        .aclk (aclk),
        .idx  (rom_idx),
        .mag  (rom_mag),
        .neg  (rom_neg)
    );

    amfm_datapath #(
        .PHASE_BITS (PHASE_BITS),
        .ADDR_BITS  (SINE_TABLE_ADDR_BITS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op      (ctrl.op),
        .accept  (accept),
        .commit  (commit),
        .in_data (s_data),
        .cfg     (cfg_reg),
        .rom_idx (rom_idx),
        .rom_mag (rom_mag),
        .rom_neg (rom_neg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.lfo_step <= LFO_STEP_RESET;
            cfg_reg.ofs_step <= OFS_STEP_RESET;
            cfg_reg.rng_step <= RNG_STEP_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_LFO_STEP: cfg_reg.lfo_step <= cfg_wdata;
                CFG_OFS_STEP: cfg_reg.ofs_step <= cfg_wdata;
                CFG_RNG_STEP: cfg_reg.rng_step <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (commit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            out_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("sequencer still idle after a request was taken");

    a_fixed_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> ##8 (ctrl.op == OP_OUT))
        else $error("microprogram did not reach the output step on time");

    a_commit_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |=> m_valid)
        else $error("result committed but output register empty");

endmodule

/* bench/tb_am_fm_modulated_oscillator.sv */
module tb_am_fm_modulated_oscillator;
    import amfm_pkg::*;

    localparam int SINE_ADDR_BITS  = 10;
    localparam int QTR_SIZE        = 1 << SINE_ADDR_BITS;
    localparam longint PEAK_AMP    = (64'd1 << (SAMPLE_BITS - 1)) - 1;
    localparam longint HALF_PI_Q30 = 64'd1686629713;
    localparam int DUT_LATENCY     = 9;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 130;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int DIRECTED_ROWS   = 24;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPARE = 2'd3;
    localparam logic [STEP_BITS-1:0]    STEP_MAX      = 31'h7FFF_FFFF;
    localparam logic [STEP_BITS-1:0]    STEP_QUARTER  = 31'h4000_0000;
    localparam logic [STEP_BITS-1:0]    STEP_ZERO     = 31'd0;

    typedef struct {
        logic                    is_write;
        logic [CFG_IDX_BITS-1:0] reg_index;
        logic [STEP_BITS-1:0]    reg_value;
        amfm_in_t                request;
        logic                    pinned;
        amfm_out_t               pinned_result;
    } stim_row_t;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    amfm_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    amfm_out_t m_data;
    logic                    cfg_wr_en;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [STEP_BITS-1:0]    cfg_wdata;

    logic [SAMPLE_BITS-2:0] quarter_wave [QTR_SIZE];
    logic [31:0]            lfo_acc;
    logic [31:0]            carrier_acc;
    logic [STEP_BITS-1:0]   lfo_step_cfg;
    logic [STEP_BITS-1:0]   ofs_step_cfg;
    logic [STEP_BITS-1:0]   rng_step_cfg;

    amfm_out_t   expected_samples [$];
    amfm_out_t   oldest_sample;
    int unsigned mismatch_count;
    int unsigned cycle_count;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    stim_row_t   directed [DIRECTED_ROWS];

    am_fm_modulated_oscillator u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic void build_quarter_wave();
        longint unsigned x, x2, term, e;
        longint          sum;
        int              i, k;
        for (i = 0; i < QTR_SIZE; i++) begin
            x    = (HALF_PI_Q30 * (2 * i + 1)) / (2 * QTR_SIZE);
            x2   = (x * x) >> 30;
            term = x;
            sum  = x;
            for (k = 1; k <= 8; k++) begin
                term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
                if (k % 2 == 1) begin
                    sum -= longint'(term);
                end else begin
                    sum += longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            e = (longint'(sum) * PEAK_AMP + (64'd1 << 29)) >> 30;
            if (e > PEAK_AMP) begin
                e = PEAK_AMP;
            end
            quarter_wave[i] = e[SAMPLE_BITS-2:0];
        end
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] sine_of(logic [31:0] phase);
        logic [1:0]                quad;
        logic [SINE_ADDR_BITS-1:0] j;
        logic signed [SAMPLE_BITS-1:0] v;
        quad = phase[31:30];
        j    = phase[29 -: SINE_ADDR_BITS];
        if (quad[0]) begin
            j = ~j;
        end
        v = $signed({1'b0, quarter_wave[j]});
        return quad[1] ? -v : v;
    endfunction

    // Works out one sample and advances both phase accumulators.
    function automatic amfm_out_t predict_sample(amfm_in_t req);
        logic signed [SAMPLE_BITS-1:0] lfo, car;
        longint          lfo_l, car_l;
        longint unsigned u, gain, mag, fmu, incr;
        logic [63:0]     res;
        amfm_out_t       r;
        lfo   = sine_of(lfo_acc);
        car   = sine_of(carrier_acc);
        lfo_l = lfo;
        car_l = car;
        u     = lfo_l + (64'd1 << (SAMPLE_BITS - 1));
        gain  = (64'd1 << (16 + SAMPLE_BITS)) - req.am_depth * u;
        mag   = (car_l < 0 ? -car_l : car_l) * gain;
        mag   = (mag + (64'd1 << (15 + SAMPLE_BITS))) >> (16 + SAMPLE_BITS);
        res   = car_l < 0 ? -mag : mag;
        fmu   = (req.fm_depth * u) >> SAMPLE_BITS;
        incr  = ofs_step_cfg + ((rng_step_cfg * fmu) >> 16);
        carrier_acc = carrier_acc + incr[31:0];
        lfo_acc     = lfo_acc + {1'b0, lfo_step_cfg};
        r.audio_out = res[SAMPLE_BITS-1:0];
        r.lfo_value = lfo;
        return r;
    endfunction

    function automatic stim_row_t item_row(logic [DEPTH_BITS-1:0] am, logic [DEPTH_BITS-1:0] fm);
        stim_row_t r;
        r = '{default: '0};
        r.request.am_depth = am;
        r.request.fm_depth = fm;
        return r;
    endfunction

    function automatic stim_row_t write_row(logic [CFG_IDX_BITS-1:0] idx,
                                            logic [STEP_BITS-1:0] value);
        stim_row_t r;
        r = '{default: '0};
        r.is_write  = 1'b1;
        r.reg_index = idx;
        r.reg_value = value;
        return r;
    endfunction

    function automatic logic [DEPTH_BITS-1:0] random_depth();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return DEPTH_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [STEP_BITS-1:0] random_step();
        case ($urandom_range(5))
            0:       return STEP_ZERO;
            1:       return STEP_MAX;
            2:       return STEP_BITS'($urandom_range(0, 1 << 24));
            default: return STEP_BITS'($urandom);
        endcase
    endfunction

    task automatic push_request(amfm_in_t req, logic pinned, amfm_out_t pinned_result);
        amfm_out_t predicted;
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        predicted = predict_sample(req);
        expected_samples.push_back(pinned ? pinned_result : predicted);
    endtask

    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge aclk);
        repeat (DUT_LATENCY) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [STEP_BITS-1:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_LFO_STEP: lfo_step_cfg = value;
            CFG_OFS_STEP: ofs_step_cfg = value;
            CFG_RNG_STEP: rng_step_cfg = value;
            default: ;
        endcase
    endtask

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (aresetn && m_valid && m_ready) begin
            if (expected_samples.size() == 0) begin
                $error("unexpected result: audio_out %0d, lfo_value %0d",
                       m_data.audio_out, m_data.lfo_value);
                mismatch_count++;
            end else begin
                oldest_sample = expected_samples.pop_front();
                if (m_data.audio_out !== oldest_sample.audio_out) begin
                    $error("audio_out: expected %0d, got %0d",
                           oldest_sample.audio_out, m_data.audio_out);
                    mismatch_count++;
                end
                if (m_data.lfo_value !== oldest_sample.lfo_value) begin
                    $error("lfo_value: expected %0d, got %0d",
                           oldest_sample.lfo_value, m_data.lfo_value);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_data         <= '0;
        cfg_wr_en      <= 1'b0;
        cfg_index      <= '0;
        cfg_wdata      <= '0;
        cycle_count    = 0;
        mismatch_count = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        build_quarter_wave();
        lfo_acc      = '0;
        carrier_acc  = '0;
        lfo_step_cfg = LFO_STEP_RESET;
        ofs_step_cfg = OFS_STEP_RESET;
        rng_step_cfg = RNG_STEP_RESET;

        // A quarter-turn LFO step visits the peak and the trough, which exercises full
        // depth, and the largest steps wrap both accumulators within a few requests.
        directed = '{
            item_row(16'h0000, 16'h0000), item_row(16'hFFFF, 16'hFFFF),
            item_row(16'hFFFF, 16'h0000), item_row(16'h0000, 16'hFFFF),
            item_row(16'hAAAA, 16'h5555), item_row(16'h5555, 16'hAAAA),
            item_row(16'h8000, 16'h0001), item_row(16'h0001, 16'h8000),
            write_row(CFG_IDX_SPARE, STEP_ZERO),
            write_row(CFG_LFO_STEP, STEP_QUARTER),
            write_row(CFG_OFS_STEP, STEP_MAX),
            write_row(CFG_RNG_STEP, STEP_MAX),
            item_row(16'hFFFF, 16'hFFFF), item_row(16'hFFFF, 16'hFFFF),
            item_row(16'hFFFF, 16'hFFFF), item_row(16'hFFFF, 16'hFFFF),
            item_row(16'hFFFF, 16'hFFFF), item_row(16'hFFFF, 16'hFFFF),
            write_row(CFG_LFO_STEP, STEP_ZERO),
            write_row(CFG_OFS_STEP, STEP_ZERO),
            write_row(CFG_RNG_STEP, STEP_ZERO),
            item_row(16'hFFFF, 16'hFFFF), item_row(16'h1234, 16'hFFFF),
            item_row(16'h0000, 16'h0000)
        };
        // Straight after reset both phases are zero, so each sine reads the first table entry.
        directed[0].pinned        = 1'b1;
        directed[0].pinned_result = '{audio_out: 16'sd25, lfo_value: 16'sd25};

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed[r]) begin
            if (directed[r].is_write) begin
                settle();
                write_reg(directed[r].reg_index, directed[r].reg_value);
            end else begin
                push_request(directed[r].request, directed[r].pinned,
                             directed[r].pinned_result);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            write_reg(CFG_LFO_STEP, random_step());
            write_reg(CFG_OFS_STEP, random_step());
            write_reg(CFG_RNG_STEP, random_step());
            if (ph % 2 == 1) begin
                write_reg(CFG_IDX_SPARE, random_step());
            end
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (ph == 2 && n == ITEMS_PER_PHASE / 2) begin
                    settle();
                end
                push_request('{am_depth: random_depth(), fm_depth: random_depth()},
                             1'b0, '0);
            end
        end

        settle();
        repeat (4 * DUT_LATENCY) @(posedge aclk);
        if (mismatch_count == 0 && expected_samples.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
